@@ design/sia_pkg.sv @@
// Package for the integer arithmetic unit: operation codes, widths, sequencer states.
// No dependencies.
package sia_pkg;
   localparam int DataWidthDefault = 32;

   typedef enum logic [4:0] {
      OP_SUB = 5'd0, OP_SUBCC = 5'd1, OP_SUBX = 5'd2, OP_SUBXCC = 5'd3,
      OP_ADD = 5'd4, OP_ADDCC = 5'd5, OP_ADDX = 5'd6, OP_ADDXCC = 5'd7,
      OP_SMUL = 5'd8, OP_SMULCC = 5'd9, OP_UMUL = 5'd10, OP_UMULCC = 5'd11,
      OP_MULX = 5'd12, OP_SDIV = 5'd13, OP_SDIVCC = 5'd14, OP_UDIV = 5'd15,
      OP_UDIVCC = 5'd16, OP_MULSCC = 5'd17
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_DIV, ST_FIX, ST_DONE
   } state_type;
endpackage

@@ design/sparc_integer_alu.sv @@
// Integer arithmetic unit with Y register and NZVC flags.
// Depends on sia_pkg.
//
// One word is taken while busy is low. Add, subtract, MULScc and unknown codes
// go from idle to the done state and then answer. Multiplies and divisions run one
// shift-add or restoring subtract step per bit, then a fix-up step for the signed
// high word, sign and saturation; a division by zero skips to the done state with a zero result.
// The result is shown for one cycle on rsp_valid and cannot be held off.
module sparc_integer_alu
   import sia_pkg::*;
#(
   parameter int DATA_WIDTH = DataWidthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [4:0]            req_type,
   input  logic [DATA_WIDTH-1:0] req_operand_a,
   input  logic [DATA_WIDTH-1:0] req_operand_b,
   output logic                  rsp_valid,
   output logic [DATA_WIDTH-1:0] rsp_result,
   output logic [3:0]            rsp_flags_out,
   output logic [DATA_WIDTH-1:0] rsp_y_out,
   output logic                  rsp_div_by_zero
);
   localparam int W = DATA_WIDTH;
   localparam int CW = $clog2(W + 1);

   state_type state_ff, state_in;
   logic [4:0] op_ff, op_in;
   logic [W-1:0] a_ff, a_in, b_ff, b_in;
   logic [W-1:0] y_ff, y_in;
   logic [3:0] fl_ff, fl_in;
   logic [W-1:0] hi_ff, hi_in, lo_ff, lo_in;   // product / remainder:quotient
   logic [CW-1:0] cnt_ff, cnt_in;
   logic neg_ff, neg_in, ovf_ff, ovf_in;
   logic [W-1:0] res_ff, res_in;
   logic dz_ff, dz_in, vld_ff, vld_in;

   // shared adder
   logic [W-1:0] add_x, add_y;
   logic add_cin;
   logic [W:0] add_s;
   assign add_s = {1'b0, add_x} + {1'b0, add_y} + {{W{1'b0}}, add_cin};

   logic [3:0] nz_f;
   logic [W-1:0] nz_r;
   assign nz_f = {nz_r[W-1], nz_r == '0, 2'b00};

   logic is_div, sgn_div, cc_div, cin;
   logic [W:0] rem_sh, rem_sub;
   logic nv;
   logic [W:0] qmax;

   always_comb begin
      state_in = state_ff; op_in = op_ff; a_in = a_ff; b_in = b_ff;
      y_in = y_ff; fl_in = fl_ff; hi_in = hi_ff; lo_in = lo_ff; cnt_in = cnt_ff;
      neg_in = neg_ff; ovf_in = ovf_ff; res_in = res_ff;
      dz_in = 1'b0; vld_in = 1'b0;
      add_x = '0; add_y = '0; add_cin = 1'b0; nz_r = '0;
      cin = fl_ff[0];
      nv = fl_ff[3] ^ fl_ff[1];
      is_div = 1'b0; sgn_div = 1'b0; cc_div = 1'b0;
      rem_sh = {hi_ff, lo_ff[W-1]};
      rem_sub = rem_sh - {1'b0, b_ff};
      qmax = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in = req_type; a_in = req_operand_a; b_in = req_operand_b;
               cnt_in = '0;
               is_div = req_type == OP_SDIV || req_type == OP_SDIVCC ||
                        req_type == OP_UDIV || req_type == OP_UDIVCC;
               sgn_div = req_type == OP_SDIV || req_type == OP_SDIVCC;
               if (req_type == OP_SMUL || req_type == OP_SMULCC ||
                   req_type == OP_UMUL || req_type == OP_UMULCC ||
                   req_type == OP_MULX) begin
                  hi_in = '0; lo_in = req_operand_b; state_in = ST_MUL;
               end else if (is_div) begin
                  if (req_operand_b == '0) begin
                     state_in = ST_DONE; res_in = '0; dz_in = 1'b1;
                  end else begin
                     // magnitudes; neg flags for sign fix-up
                     neg_in = sgn_div & (y_ff[W-1] ^ req_operand_b[W-1]);
                     {hi_in, lo_in} = (sgn_div && y_ff[W-1]) ?
                                      -{y_ff, req_operand_a} : {y_ff, req_operand_a};
                     b_in = (sgn_div && req_operand_b[W-1]) ? -req_operand_b
                                                            : req_operand_b;
                     ovf_in = 1'b0;
                     state_in = ST_DIV;
                  end
               end else begin
                  state_in = ST_DONE; res_in = '0;
                  priority case (1'b1)
                     req_type <= OP_SUBXCC: begin
                        add_x = req_operand_a; add_y = ~req_operand_b;
                        add_cin = !(req_type[1] & cin);
                        res_in = add_s[W-1:0];
                        if (req_type[0]) begin
                           nz_r = add_s[W-1:0];
                           fl_in = nz_f | {2'b00,
                              (req_operand_a[W-1] ^ req_operand_b[W-1]) &
                              (req_operand_a[W-1] ^ add_s[W-1]), !add_s[W]};
                        end
                     end
                     req_type <= OP_ADDXCC: begin
                        add_x = req_operand_a; add_y = req_operand_b;
                        add_cin = req_type[1] & cin;
                        res_in = add_s[W-1:0];
                        if (req_type[0]) begin
                           nz_r = add_s[W-1:0];
                           fl_in = nz_f | {2'b00,
                              !(req_operand_a[W-1] ^ req_operand_b[W-1]) &
                              (req_operand_a[W-1] ^ add_s[W-1]), add_s[W]};
                        end
                     end
                     req_type == OP_MULSCC: begin
                        add_x = {nv, req_operand_a[W-1:1]};
                        add_y = y_ff[0] ? req_operand_b : '0;
                        res_in = add_s[W-1:0];
                        nz_r = add_s[W-1:0];
                        fl_in = nz_f | {2'b00,
                           !(add_x[W-1] ^ add_y[W-1]) & (add_x[W-1] ^ add_s[W-1]),
                           add_s[W]};
                        y_in = {req_operand_a[0], y_ff[W-1:1]};
                     end
                     default: ;
                  endcase
               end
            end
         end
         ST_MUL: begin
            // unsigned shift-add, one bit a cycle
            add_x = hi_ff; add_y = lo_ff[0] ? a_ff : '0;
            {hi_in, lo_in} = {add_s, lo_ff[W-1:1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(W - 1)) state_in = ST_FIX;
         end
         ST_DIV: begin
            // restoring step; quotient bit W-1+.. beyond range flags overflow
            if (!rem_sub[W]) begin
               hi_in = rem_sub[W-1:0]; lo_in = {lo_ff[W-2:0], 1'b1};
            end else begin
               hi_in = rem_sh[W-1:0]; lo_in = {lo_ff[W-2:0], 1'b0};
            end
            // high quotient bits exist when the top partial remainder >= divisor
            if (cnt_ff == '0 && hi_ff >= b_ff) ovf_in = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(W - 1)) state_in = ST_FIX;
         end
         ST_FIX: begin
            state_in = ST_DONE;
            is_div = op_ff == OP_SDIV || op_ff == OP_SDIVCC ||
                     op_ff == OP_UDIV || op_ff == OP_UDIVCC;
            sgn_div = op_ff == OP_SDIV || op_ff == OP_SDIVCC;
            cc_div = op_ff == OP_SDIVCC || op_ff == OP_UDIVCC;
            if (is_div) begin
               // largest magnitude: 2^(W-1) when negative, 2^(W-1)-1 otherwise
               qmax = {2'b00, {(W-1){1'b1}}} + {{W{1'b0}}, neg_ff};
               if (!sgn_div) begin
                  res_in = ovf_ff ? '1 : lo_ff;
                  nz_r = res_in;
                  if (cc_div) fl_in = nz_f | {2'b00, ovf_ff, 1'b0};
               end else begin
                  if (ovf_ff || {1'b0, lo_ff} > qmax) begin
                     res_in = neg_ff ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                     nz_r = res_in;
                     if (cc_div) fl_in = nz_f | 4'b0010;
                  end else begin
                     res_in = neg_ff ? -lo_ff : lo_ff;
                     nz_r = res_in;
                     if (cc_div) fl_in = nz_f;
                  end
               end
            end else begin
               res_in = lo_ff;
               if (op_ff != OP_MULX) begin
                  // signed correction of high word
                  y_in = hi_ff - ((op_ff == OP_SMUL || op_ff == OP_SMULCC) ?
                         ((a_ff[W-1] ? b_ff : '0) + (b_ff[W-1] ? a_ff : '0)) : '0);
                  nz_r = lo_ff;
                  if (op_ff == OP_SMULCC || op_ff == OP_UMULCC) fl_in = nz_f;
               end
            end
         end
         ST_DONE: begin
            vld_in = 1'b1; dz_in = dz_ff; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; y_ff <= '0; fl_ff <= '0; vld_ff <= 1'b0; dz_ff <= 1'b0;
      end else begin
         state_ff <= state_in; y_ff <= y_in; fl_ff <= fl_in;
         vld_ff <= vld_in; dz_ff <= dz_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; a_ff <= a_in; b_ff <= b_in; hi_ff <= hi_in; lo_ff <= lo_in;
      cnt_ff <= cnt_in; neg_ff <= neg_in; ovf_ff <= ovf_in;
      res_ff <= res_in;
   end

   assign busy = state_ff != ST_IDLE;
   assign rsp_valid = vld_ff;
   assign rsp_result = res_ff;
   assign rsp_flags_out = fl_ff;
   assign rsp_y_out = y_ff;
   assign rsp_div_by_zero = vld_ff & dz_ff;

`ifndef NO_ASSERTIONS
   a_vld_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while busy");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("start not taken");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double response");
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_div_by_zero |-> rsp_result == '0) else $error("div by zero result");
`endif
endmodule

@@ sim/tb_top.sv @@
// Testbench for sparc_integer_alu: random and directed arithmetic words, self-checking.
// Depends on sia_pkg and the sparc_integer_alu RTL.
`timescale 1ns / 100ps

module tb_top;
   import sia_pkg::*;

   typedef struct packed {
      logic [4:0]  kind;
      logic [31:0] a;
      logic [31:0] b;
   } alu_word_type;

   typedef struct packed {
      logic [31:0] res;
      logic [3:0]  nzvc;
      logic [31:0] y;
      logic        dz;
   } alu_out_type;

   localparam logic [3:0] FL_N = 4'b1000;
   localparam logic [3:0] FL_Z = 4'b0100;
   localparam logic [3:0] FL_V = 4'b0010;
   localparam logic [3:0] FL_C = 4'b0001;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [4:0]  req_type = '0;
   logic [31:0] req_operand_a = '0;
   logic [31:0] req_operand_b = '0;
   logic        rsp_valid;
   logic [31:0] rsp_result;
   logic [3:0]  rsp_flags_out;
   logic [31:0] rsp_y_out;
   logic        rsp_div_by_zero;

   alu_word_type pending_words[$];
   alu_out_type  expected_outs[$];
   logic [31:0] pred_y = '0;
   logic [3:0]  pred_flags = '0;
   int send_idle_pct = 0;
   int mismatches = 0;
   int words_sent = 0;
   int results_seen = 0;
   int div_words = 0;

   sparc_integer_alu i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid), .rsp_result(rsp_result), .rsp_flags_out(rsp_flags_out),
      .rsp_y_out(rsp_y_out), .rsp_div_by_zero(rsp_div_by_zero)
   );

   always #10 clock = ~clock;

   function automatic logic [3:0] nz_bits(input logic [31:0] r);
      return (r[31] ? FL_N : 4'b0) | ((r == 0) ? FL_Z : 4'b0);
   endfunction

   function automatic logic [31:0] add_word(input logic [31:0] a, input logic [31:0] b,
                                            input logic cin, input logic cc);
      logic [32:0] wide;
      logic [31:0] r;
      wide = {1'b0, a} + {1'b0, b} + 33'(cin);
      r = wide[31:0];
      if (cc)
         pred_flags = nz_bits(r) | ((~(a ^ b) & (a ^ r)) >> 31 ? FL_V : 4'b0)
                      | (wide[32] ? FL_C : 4'b0);
      return r;
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] a, input logic [31:0] b,
                                            input logic bin, input logic cc);
      logic [31:0] r;
      r = a - b - 32'(bin);
      if (cc)
         pred_flags = nz_bits(r) | (((a ^ b) & (a ^ r)) >> 31 ? FL_V : 4'b0)
                      | ((33'(a) < 33'(b) + 33'(bin)) ? FL_C : 4'b0);
      return r;
   endfunction

   function automatic logic [31:0] mul_word(input logic [31:0] a, input logic [31:0] b,
                                            input logic sgn, input logic cc);
      logic [63:0] p;
      if (sgn) p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
      else     p = {32'b0, a} * {32'b0, b};
      pred_y = p[63:32];
      if (cc) pred_flags = nz_bits(p[31:0]);
      return p[31:0];
   endfunction

   function automatic logic [31:0] div_word(input logic [31:0] a, input logic [31:0] b,
                                            input logic sgn, input logic cc);
      logic [63:0] n, mn, md, q;
      logic [31:0] r;
      logic ovf, nneg, dneg;
      n = {pred_y, a};
      if (sgn) begin
         nneg = n[63];
         dneg = b[31];
         mn = nneg ? -n : n;
         md = dneg ? {32'b0, -b} : {32'b0, b};
         if (md == 0) md = 64'h1_0000_0000;
         q = mn / md;
         if (nneg != dneg) begin
            ovf = q > 64'h8000_0000;
            r = ovf ? 32'h8000_0000 : -q[31:0];
         end else begin
            ovf = q > 64'h7fff_ffff;
            r = ovf ? 32'h7fff_ffff : q[31:0];
         end
      end else begin
         q = n / {32'b0, b};
         ovf = q > 64'hffff_ffff;
         r = ovf ? 32'hffff_ffff : q[31:0];
      end
      if (cc) pred_flags = nz_bits(r) | (ovf ? FL_V : 4'b0);
      return r;
   endfunction

   task automatic predict_alu(input alu_word_type w);
      alu_out_type o;
      logic cf;
      logic [31:0] op1, op2;
      cf = pred_flags[0];
      o = '0;
      case (w.kind)
         OP_SUB:    o.res = sub_word(w.a, w.b, 1'b0, 1'b0);
         OP_SUBCC:  o.res = sub_word(w.a, w.b, 1'b0, 1'b1);
         OP_SUBX:   o.res = sub_word(w.a, w.b, cf, 1'b0);
         OP_SUBXCC: o.res = sub_word(w.a, w.b, cf, 1'b1);
         OP_ADD:    o.res = add_word(w.a, w.b, 1'b0, 1'b0);
         OP_ADDCC:  o.res = add_word(w.a, w.b, 1'b0, 1'b1);
         OP_ADDX:   o.res = add_word(w.a, w.b, cf, 1'b0);
         OP_ADDXCC: o.res = add_word(w.a, w.b, cf, 1'b1);
         OP_SMUL:   o.res = mul_word(w.a, w.b, 1'b1, 1'b0);
         OP_SMULCC: o.res = mul_word(w.a, w.b, 1'b1, 1'b1);
         OP_UMUL:   o.res = mul_word(w.a, w.b, 1'b0, 1'b0);
         OP_UMULCC: o.res = mul_word(w.a, w.b, 1'b0, 1'b1);
         OP_MULX:   o.res = w.a * w.b;
         OP_SDIV, OP_SDIVCC, OP_UDIV, OP_UDIVCC: begin
            if (w.b == 0) o.dz = 1'b1;
            else o.res = div_word(w.a, w.b, w.kind == OP_SDIV || w.kind == OP_SDIVCC,
                                  w.kind == OP_SDIVCC || w.kind == OP_UDIVCC);
         end
         OP_MULSCC: begin
            op1 = {pred_flags[3] ^ pred_flags[1], w.a[31:1]};
            op2 = pred_y[0] ? w.b : 32'b0;
            o.res = add_word(op1, op2, 1'b0, 1'b1);
            pred_y = {w.a[0], pred_y[31:1]};
         end
         default: ;
      endcase
      o.nzvc = pred_flags;
      o.y = pred_y;
      expected_outs.push_back(o);
   endtask

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 32'h0;
         1: return 32'hffff_ffff;
         2: return 32'h8000_0000;
         3: return 32'h7fff_ffff;
         4: return 32'($urandom_range(0, 15));
         default: return $urandom;
      endcase
   endfunction

   function automatic alu_word_type rand_word();
      alu_word_type w;
      w.a = pick_operand();
      w.b = pick_operand();
      if ($urandom_range(0, 39) == 0) w.kind = 5'($urandom_range(18, 31));
      else w.kind = 5'($urandom_range(0, 17));
      // keep most divisions off a zero divisor so the quotient path is exercised
      if (w.kind inside {OP_SDIV, OP_SDIVCC, OP_UDIV, OP_UDIVCC} && $urandom_range(0, 3) != 0
          && w.b == 0)
         w.b = $urandom | 32'h1;
      return w;
   endfunction

   // driver: a raised start is always taken at the next rising edge
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start) begin
         start <= 1'b0;
      end else if (pending_words.size() > 0 && !busy
                   && $urandom_range(0, 99) >= send_idle_pct) begin
         req_type <= pending_words[0].kind;
         req_operand_a <= pending_words[0].a;
         req_operand_b <= pending_words[0].b;
         start <= 1'b1;
      end
   end

   // acceptance and prediction at the rising edge
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         predict_alu(pending_words.pop_front());
         words_sent++;
         if (req_type inside {OP_SDIV, OP_SDIVCC, OP_UDIV, OP_UDIVCC}) div_words++;
      end
   end

   // monitor
   always @(posedge clock) begin
      alu_out_type e;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (expected_outs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", rsp_result);
         end else begin
            e = expected_outs.pop_front();
            if (rsp_result !== e.res || rsp_flags_out !== e.nzvc || rsp_y_out !== e.y
                || rsp_div_by_zero !== e.dz) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp res %h nzvc %b y %h dz %b, got %h %b %h %b",
                           e.res, e.nzvc, e.y, e.dz, rsp_result, rsp_flags_out,
                           rsp_y_out, rsp_div_by_zero);
            end
         end
      end
   end

   task automatic drain();
      while (pending_words.size() > 0 || start || expected_outs.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      alu_word_type w;
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: every operation on edge operands, carry chains, zero divisors
      for (int k = 0; k <= 17; k++) begin
         w.kind = 5'(k);
         w.a = (k % 2) ? 32'hffff_ffff : 32'h8000_0000;
         w.b = (k % 3 == 0) ? 32'h0 : 32'h7fff_ffff;
         pending_words.push_back(w);
      end
      pending_words.push_back('{OP_ADDCC, 32'hffff_ffff, 32'h1});
      pending_words.push_back('{OP_ADDXCC, 32'hffff_ffff, 32'h0});
      pending_words.push_back('{OP_SUBXCC, 32'h0, 32'hffff_ffff});
      pending_words.push_back('{OP_SMULCC, 32'h8000_0000, 32'hffff_ffff});
      pending_words.push_back('{OP_SDIVCC, 32'h0, 32'hffff_ffff});
      pending_words.push_back('{OP_UDIVCC, 32'hffff_ffff, 32'h1});
      pending_words.push_back('{5'd31, 32'hffff_ffff, 32'hffff_ffff});
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 79 : 0;
         for (int i = 0; i < 250; i++) pending_words.push_back(rand_word());
         drain();
      end
      repeat (40) @(posedge clock);

      $display("%0d words issued (%0d divisions), %0d results checked, %0d mismatches",
               words_sent, div_words, results_seen, mismatches);
      if (mismatches == 0 && expected_outs.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #5ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
